// File: rtl/tdq_pkg.sv
// tdq_pkg: shared constants, codes and structs of the timer deadline queue
// depends on nothing; imported by the interfaces, the cell, the top level and the checker
package tdq_pkg;

	localparam int DEPTH     = 16;
	localparam int TIME_BITS = 48;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);

	// fixed field widths of the channels
	localparam int FTIME_W = 48;
	localparam int IVAL_W  = 24;
	localparam int ID_W    = 8;
	localparam int KIND_W  = 2;

	localparam int SUM_W = ((TIME_BITS > IVAL_W) ? TIME_BITS : IVAL_W) + 1;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	// input function codes
	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ADD_OK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADD_REJ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_TICK_END = 2'd3;

	// commands broadcast to the cells
	localparam logic [2:0] OP_NOP       = 3'd0;
	localparam logic [2:0] OP_WRITE     = 3'd1;
	localparam logic [2:0] OP_FIRE      = 3'd2;
	localparam logic [2:0] OP_CLR_FIRED = 3'd3;
	localparam logic [2:0] OP_REARM     = 3'd4;

	typedef struct packed {
		logic [2:0]           op;
		logic [IDX_W-1:0]     idx;
		logic [TIME_BITS-1:0] time_val;
		logic [IVAL_W-1:0]    interval;
		logic [ID_W-1:0]      id;
		logic                 fire_filter;
	} bus_t;

	// search record handed from cell to cell
	typedef struct packed {
		logic                 go;
		logic                 found;
		logic [TIME_BITS-1:0] dl;
		logic [ID_W-1:0]      id;
		logic [IDX_W-1:0]     idx;
		logic                 free_found;
		logic [IDX_W-1:0]     free_idx;
		logic                 dup;
	} link_t;

endpackage

// File: rtl/tdq_in_if.sv
// tdq_in_if: valid/ready channel carrying one input beat (add or tick)
// depends on tdq_pkg
interface tdq_in_if;
	import tdq_pkg::*;

	logic               valid;
	logic               ready;
	logic               func;
	logic [FTIME_W-1:0] time_value;
	logic [IVAL_W-1:0]  reload_interval;
	logic [ID_W-1:0]    timer_id;

	modport source (output valid, func, time_value, reload_interval, timer_id, input ready);
	modport sink (input valid, func, time_value, reload_interval, timer_id, output ready);
endinterface

// File: rtl/tdq_out_if.sv
// tdq_out_if: valid/ready channel carrying one result beat
// depends on tdq_pkg
interface tdq_out_if;
	import tdq_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [ID_W-1:0]    fired_id;
	logic               earliest_changed;
	logic [FTIME_W-1:0] next_deadline;
	logic               deadline_valid;
	logic               last;

	modport source (output valid, kind, fired_id, earliest_changed, next_deadline,
		deadline_valid, last, input ready);
	modport sink (input valid, kind, fired_id, earliest_changed, next_deadline,
		deadline_valid, last, output ready);
endinterface

// File: rtl/tdq_cell.sv
// tdq_cell: one timer slot plus one registered stage of the search chain
// depends on tdq_pkg
module tdq_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [tdq_pkg::IDX_W-1:0] slot_idx,
	input  tdq_pkg::bus_t             bus,
	input  tdq_pkg::link_t            link_in,
	output tdq_pkg::link_t            link_out
);
	import tdq_pkg::*;

	logic                 valid_q;
	logic                 fired_q;
	logic [TIME_BITS-1:0] dl_q;
	logic [IVAL_W-1:0]    iv_q;
	logic [ID_W-1:0]      id_q;
	link_t                link_q;
	link_t                link_d;
	logic [SUM_W-1:0]     sum;
	logic [TIME_BITS-1:0] rearm_dl;
	logic                 sel;
	logic                 cand;
	logic                 better;

	assign sel = (bus.idx == slot_idx);

	// saturating re-arm deadline
	assign sum      = SUM_W'(bus.time_val) + SUM_W'(iv_q);
	assign rearm_dl = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];

	assign cand   = valid_q && (!bus.fire_filter || (!fired_q && (dl_q <= bus.time_val)));
	assign better = !link_in.found || (dl_q < link_in.dl) ||
		((dl_q == link_in.dl) && (id_q < link_in.id));

	always_comb begin
		link_d = link_in;
		if (cand && better) begin
			link_d.found = 1'b1;
			link_d.dl    = dl_q;
			link_d.id    = id_q;
			link_d.idx   = slot_idx;
		end
		if (!valid_q && !link_in.free_found) begin
			link_d.free_found = 1'b1;
			link_d.free_idx   = slot_idx;
		end
		if (valid_q && (dl_q == bus.time_val) && (id_q == bus.id))
			link_d.dup = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			fired_q <= 1'b0;
			link_q  <= '0;
		end else begin
			link_q <= link_d;
			unique case (bus.op)
				OP_WRITE: begin
					if (sel)
						valid_q <= 1'b1;
				end
				OP_FIRE: begin
					if (sel)
						fired_q <= 1'b1;
				end
				OP_CLR_FIRED: fired_q <= 1'b0;
				OP_REARM: begin
					if (fired_q && (iv_q == '0))
						valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// slot payload, no reset
	always_ff @(posedge clk) begin
		if ((bus.op == OP_WRITE) && sel) begin
			dl_q <= bus.time_val;
			iv_q <= bus.interval;
			id_q <= bus.id;
		end else if ((bus.op == OP_REARM) && fired_q && (iv_q != '0)) begin
			dl_q <= rearm_dl;
		end
	end

	assign link_out = link_q;

endmodule

// File: rtl/timer_deadline_queue_core.sv
// timer_deadline_queue_core: an add makes one chain pass from accept to result beat;
// a tick makes one chain pass per fired timer, one pass that finds nothing left due
// and one pass for the next deadline; the row of DEPTH cells is the search path.
// one item at a time; item.ready is high whenever the sequencer is idle, also while
// the final result beat still waits in the output register.
// asynchronous reset empties the table and drops any pending result beat.
module timer_deadline_queue_core (
	input logic  clk,
	input logic  arst_n,
	tdq_in_if.sink    item,
	tdq_out_if.source result
);
	import tdq_pkg::*;

	// sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_START = 2'd1;
	localparam logic [1:0] S_WAIT  = 2'd2;
	localparam logic [1:0] S_RES   = 2'd3;

	// what the current chain pass searches for
	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_FIRE = 2'd1;
	localparam logic [1:0] MODE_LAST = 2'd2;

	logic [1:0]           state_q, state_d;
	logic [1:0]           mode_q, mode_d;
	logic [TIME_BITS-1:0] time_q;
	logic [IVAL_W-1:0]    iv_q;
	logic [ID_W-1:0]      id_q;
	link_t                res_q;
	bus_t                 bus;
	link_t                links [DEPTH+1];

	// output register
	logic                 out_valid_q;
	logic [KIND_W-1:0]    kind_q;
	logic [ID_W-1:0]      fired_id_q;
	logic                 changed_q;
	logic [TIME_BITS-1:0] nd_q;
	logic                 dv_q;
	logic                 last_q;

	logic                 out_free;
	logic                 out_load;
	logic [KIND_W-1:0]    o_kind;
	logic [ID_W-1:0]      o_id;
	logic                 o_changed;
	logic [TIME_BITS-1:0] o_nd;
	logic                 o_dv;
	logic                 o_last;
	logic                 item_acc;
	logic                 add_ok;

	assign item.ready = (state_q == S_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	// add is taken when a slot is free and no pending timer has the same key
	assign add_ok = res_q.free_found && !res_q.dup;

	// search chain: a record enters cell 0 and passes the register of every cell before it leaves the last cell
	always_comb begin
		links[0]    = '0;
		links[0].go = (state_q == S_START);
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		tdq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.slot_idx (IDX_W'(g)),
			.bus      (bus),
			.link_in  (links[g]),
			.link_out (links[g+1])
		);
	end

	// sequencer
	always_comb begin
		state_d         = state_q;
		mode_d          = mode_q;
		bus.op          = OP_NOP;
		bus.idx         = res_q.idx;
		bus.time_val    = time_q;
		bus.interval    = iv_q;
		bus.id          = id_q;
		bus.fire_filter = (mode_q == MODE_FIRE);
		out_load        = 1'b0;
		o_kind          = KIND_TICK_END;
		o_id            = '0;
		o_changed       = 1'b0;
		o_nd            = res_q.found ? res_q.dl : '0;
		o_dv            = res_q.found;
		o_last          = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (item_acc) begin
					state_d = S_START;
					if (item.func == FUNC_TICK) begin
						mode_d = MODE_FIRE;
						bus.op = OP_CLR_FIRED;
					end else begin
						mode_d = MODE_ADD;
					end
				end
			end
			S_START: state_d = S_WAIT;
			S_WAIT: begin
				if (links[DEPTH].go)
					state_d = S_RES;
			end
			S_RES: begin
				unique case (mode_q)
					MODE_ADD: begin
						if (add_ok) begin
							o_kind    = KIND_ADD_OK;
							o_changed = !res_q.found || (time_q < res_q.dl);
							o_dv      = 1'b1;
							// the new deadline may now be the earliest
							o_nd      = (res_q.found && (res_q.dl < time_q)) ?
								res_q.dl : time_q;
						end else begin
							o_kind = KIND_ADD_REJ;
						end
						if (out_free) begin
							out_load = 1'b1;
							state_d  = S_IDLE;
							if (add_ok) begin
								bus.op  = OP_WRITE;
								bus.idx = res_q.free_idx;
							end
						end
					end
					MODE_FIRE: begin
						if (res_q.found) begin
							o_kind = KIND_FIRED;
							o_id   = res_q.id;
							o_nd   = '0;
							o_dv   = 1'b0;
							o_last = 1'b0;
							if (out_free) begin
								out_load = 1'b1;
								bus.op   = OP_FIRE;
								state_d  = S_START;
							end
						end else begin
							// nothing left to fire: re-arm or free, then find the earliest
							bus.op  = OP_REARM;
							mode_d  = MODE_LAST;
							state_d = S_START;
						end
					end
					MODE_LAST: begin
						if (out_free) begin
							out_load = 1'b1;
							state_d  = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_ADD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	// item fields, chain result and result beat payload
	always_ff @(posedge clk) begin
		if (item_acc) begin
			time_q <= TIME_BITS'(item.time_value);
			iv_q   <= item.reload_interval;
			id_q   <= item.timer_id;
		end
		if (links[DEPTH].go)
			res_q <= links[DEPTH];
		if (out_load) begin
			kind_q     <= o_kind;
			fired_id_q <= o_id;
			changed_q  <= o_changed;
			nd_q       <= o_nd;
			dv_q       <= o_dv;
			last_q     <= o_last;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.kind             = kind_q;
	assign result.fired_id         = fired_id_q;
	assign result.earliest_changed = changed_q;
	assign result.next_deadline    = FTIME_W'(nd_q);
	assign result.deadline_valid   = dv_q;
	assign result.last             = last_q;

endmodule

// File: rtl/tdq_chk.sv
// tdq_chk: port-level checks of the timer deadline queue, bound to the top level
// depends on tdq_pkg and timer_deadline_queue_core
module tdq_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [tdq_pkg::KIND_W-1:0] kind,
	input logic [tdq_pkg::ID_W-1:0]   fired_id,
	input logic                       last
);
	import tdq_pkg::*;

	logic             in_acc;
	logic             out_acc;
	logic [1:0]       open_q;
	logic [CNT_W-1:0] fire_cnt_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items accepted whose final beat is not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= '0;
			fire_cnt_q <= '0;
		end else begin
			open_q <= open_q + 2'(in_acc) - 2'(out_acc && last);
			if (out_acc && last)
				fire_cnt_q <= '0;
			else if (out_acc)
				fire_cnt_q <= fire_cnt_q + 1'b1;
		end
	end

	a_no_orphan_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (open_q != 2'd0))
		else $error("result beat without an open item");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (open_q <= 2'd1))
		else $error("item accepted while another is still being worked");

	a_last_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind != KIND_FIRED)))
		else $error("last flag does not match result kind");

	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && (kind == KIND_FIRED)) |-> (fire_cnt_q < CNT_W'(DEPTH)))
		else $error("more fired beats than slots in one tick");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(fired_id)))
		else $error("stalled result beat changed");

endmodule

bind timer_deadline_queue_core tdq_chk u_tdq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.kind      (result.kind),
	.fired_id  (result.fired_id),
	.last      (result.last)
);
